[design/humidity_temp_frame_decoder_macros.svh]
// Assertion macros shared by the frame decoder checkers.
// Depends on nothing; each macro expects i_clk and i_rst_n in scope.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HTFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frame decoder check failed");

// Next-cycle implication, checked outside reset.
`define HTFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frame decoder check failed");

`endif

[design/htfd_pkg.sv]
// Shared types, constants and the CRC function of the frame decoder.
// Used by every module of the design; depends on nothing.
package htfd_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int POS_W       = 3;
    localparam logic [POS_W-1:0] LAST_POS  = 3'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] CRC_BYTES = 3'(FRAME_BYTES - 2);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_NACK = 2'd1;
    localparam logic [1:0] STAT_CRC  = 2'd2;

    typedef struct packed {
        logic       bus_nack;
        logic       frame_start;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] temperature_tenths;
        logic [15:0]        humidity_tenths;
    } t_result;

    // Reflected CRC-16 update by one byte, LSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[design/htfd_in_stage.sv]
// Input register of the frame decoder: holds one received beat.
// Depends on htfd_pkg.
module htfd_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  htfd_pkg::t_item i_item,
    output logic            o_ready,
    input  logic            i_take,
    output logic            o_valid,
    output htfd_pkg::t_item o_item
);

    logic            r_valid;
    htfd_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

[design/htfd_frame.sv]
// Frame tracking, CRC check and field decode for one held beat.
// Depends on htfd_pkg for the CRC function, constants and types.
module htfd_frame (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  htfd_pkg::t_item   i_item,
    input  logic              i_out_free,
    output logic              o_take,
    output logic              o_res_valid,
    output htfd_pkg::t_result o_res
);

    logic [htfd_pkg::POS_W-1:0] r_pos, n_pos;
    logic [15:0]                r_crc, n_crc;
    logic [7:0]                 r_cap [2:6];

    logic [htfd_pkg::POS_W-1:0] pos_eff;
    logic [15:0]                crc_eff;
    logic [14:0]                mag;
    logic [15:0]                rx_crc;

    assign o_take  = i_valid && i_out_free;
    assign pos_eff = i_item.frame_start ? '0 : r_pos;
    assign crc_eff = i_item.frame_start ? htfd_pkg::CRC_INIT : r_crc;
    assign rx_crc  = {i_item.rx_byte, r_cap[6]};
    assign mag     = {r_cap[4][6:0], r_cap[5]};

    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_item.bus_nack) begin
            n_pos        = '0;
            n_crc        = htfd_pkg::CRC_INIT;
            o_res_valid  = 1'b1;
            o_res.status = htfd_pkg::STAT_NACK;
        end else if (pos_eff != htfd_pkg::LAST_POS) begin
            n_pos = pos_eff + 1'b1;
            n_crc = (pos_eff < htfd_pkg::CRC_BYTES)
                    ? htfd_pkg::crc_byte(crc_eff, i_item.rx_byte) : crc_eff;
        end else begin
            n_pos       = '0;
            n_crc       = htfd_pkg::CRC_INIT;
            o_res_valid = 1'b1;
            if (rx_crc != crc_eff) begin
                o_res.status = htfd_pkg::STAT_CRC;
            end else begin
                o_res.status          = htfd_pkg::STAT_OK;
                o_res.humidity_tenths = {r_cap[2], r_cap[3]};
                // Sign-magnitude to two's complement; negative zero comes out as zero.
                o_res.temperature_tenths = r_cap[4][7] ? -$signed({1'b0, mag})
                                                       : $signed({1'b0, mag});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_crc <= htfd_pkg::CRC_INIT;
        end else if (o_take) begin
            r_pos <= n_pos;
            r_crc <= n_crc;
        end
    end

    // Only the bytes used later are kept; bytes 0 and 1 are not checked.
    always_ff @(posedge i_clk) begin
        if (o_take && !i_item.bus_nack) begin
            for (int k = 2; k <= 6; k++) begin
                if (pos_eff == 3'(k)) begin
                    r_cap[k] <= i_item.rx_byte;
                end
            end
        end
    end

endmodule

[design/htfd_out_stage.sv]
// Result register of the frame decoder, drives the output stream.
// Depends on htfd_pkg for the result type.
module htfd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  htfd_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output htfd_pkg::t_result o_res
);

    logic              r_valid;
    htfd_pkg::t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

[design/humidity_temp_frame_decoder.sv]
// Humidity/temperature response frame decoder, top level.
// Depends on htfd_pkg, htfd_in_stage, htfd_frame and htfd_out_stage.
//
// Takes the sensor's 8-byte read response one byte per beat and emits one
// result beat per frame (status, temperature in 0.1 degC as two's complement,
// humidity in 0.1 %RH), or one at once on a nack. A new byte is accepted every
// cycle while the output is not stalled; a result beat is registered in the
// result register from the byte held in the input register. While a result
// beat waits on a stalled output, the held byte stays in the input register
// and the input side stops taking bytes. The rate is set by the frame stage,
// which runs the unrolled 8-bit CRC-16 update combinationally. After the
// eighth byte the next byte begins a new frame even without frame_start.
module humidity_temp_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  i_s_tuser,   // [0] frame_start, [1] bus_nack
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [15:0] temperature_tenths, [31:16] humidity_tenths
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    htfd_pkg::t_item   in_item, held_item;
    htfd_pkg::t_result res, out_res;
    logic              held_valid, take, res_valid, out_free;

    assign in_item.rx_byte     = i_s_tdata;
    assign in_item.frame_start = i_s_tuser[0];
    assign in_item.bus_nack    = i_s_tuser[1];

    htfd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_item  (in_item),
        .o_ready (o_s_tready),
        .i_take  (take),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    htfd_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (held_valid),
        .i_item      (held_item),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    htfd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take && res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (out_res)
    );

    assign o_m_tdata = {out_res.humidity_tenths, out_res.temperature_tenths};
    assign o_m_tuser = out_res.status;

endmodule

[design/htfd_checker.sv]
// Port-level checks for the frame decoder, bound to the top level.
// Depends on htfd_pkg and humidity_temp_frame_decoder_macros.svh.
`include "humidity_temp_frame_decoder_macros.svh"

module htfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    // Only the three defined status codes ever leave the block.
    `HTFD_ASSERT_NOW(a_status_code, o_m_tvalid, o_m_tuser <= htfd_pkg::STAT_CRC)

    // Failed frames carry no measurement.
    `HTFD_ASSERT_NOW(a_fail_zero, o_m_tvalid && (o_m_tuser != htfd_pkg::STAT_OK), o_m_tdata == 32'd0)

    // With the result register empty the input side is never stalled.
    `HTFD_ASSERT_NOW(a_ready_when_empty, !o_m_tvalid, o_s_tready)

    // A stalled result beat holds.
    `HTFD_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (.*);

[dv/humidity_temp_frame_decoder_tb.sv]
// Self-checking testbench for humidity_temp_frame_decoder: sends response frames byte by byte
// and compares every result beat against a built-in frame decoder model.
// Depends on htfd_pkg and the humidity_temp_frame_decoder RTL.
module humidity_temp_frame_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET   = 1750;
    localparam int PHASE_BEATS   = 220;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int STALL_LIMIT   = 3000;
    localparam int MAX_PRINTED   = 40;

    typedef enum int {
        PH_STEADY,
        PH_SRC_GAPS,
        PH_SINK_STALLS,
        PH_BOTH
    } idle_phase_e;

    // Decodes frames the same way the block should and keeps the readings still owed.
    class reading_scoreboard;
        htfd_pkg::t_result expected_readings[$];
        logic [2:0]        frame_pos;
        logic [15:0]       crc_run;
        logic [7:0]        held_bytes [7];
        int                mismatches;

        function new();
            frame_pos  = '0;
            crc_run    = htfd_pkg::CRC_INIT;
            mismatches = 0;
            foreach (held_bytes[i]) held_bytes[i] = '0;
        endfunction

        // Reflected CRC-16, one input bit per step, LSB first.
        static function logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
            logic [15:0] r;
            logic        fb;
            r = acc;
            for (int i = 0; i < 8; i++) begin
                fb = r[0] ^ b[i];
                r  = {1'b0, r[15:1]};
                if (fb) begin
                    r = r ^ htfd_pkg::CRC_POLY;
                end
            end
            return r;
        endfunction

        function void report(input string msg);
            if (mismatches < MAX_PRINTED) begin
                $display("ERROR at %0t ns: %s", $time, msg);
            end
            mismatches++;
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        function void note_input(input htfd_pkg::t_item it);
            htfd_pkg::t_result r;
            logic [15:0]       got_crc;
            logic [15:0]       mag;
            r.status             = htfd_pkg::STAT_OK;
            r.temperature_tenths = '0;
            r.humidity_tenths    = '0;
            if (it.bus_nack) begin
                frame_pos = '0;
                crc_run   = htfd_pkg::CRC_INIT;
                r.status  = htfd_pkg::STAT_NACK;
                expected_readings.push_back(r);
                return;
            end
            if (it.frame_start) begin
                frame_pos = '0;
                crc_run   = htfd_pkg::CRC_INIT;
            end
            if (frame_pos != htfd_pkg::LAST_POS) begin
                if (frame_pos < htfd_pkg::CRC_BYTES) begin
                    crc_run = crc16_step(crc_run, it.rx_byte);
                end
                held_bytes[frame_pos] = it.rx_byte;
                frame_pos = frame_pos + 3'd1;
                return;
            end
            got_crc   = {it.rx_byte, held_bytes[6]};
            frame_pos = '0;
            if (got_crc != crc_run) begin
                r.status = htfd_pkg::STAT_CRC;
            end else begin
                mag = {1'b0, held_bytes[4][6:0], held_bytes[5]};
                r.humidity_tenths    = {held_bytes[2], held_bytes[3]};
                r.temperature_tenths = held_bytes[4][7] ? 16'd0 - mag : mag;
            end
            crc_run = htfd_pkg::CRC_INIT;
            expected_readings.push_back(r);
        endfunction

        function void check_result(input htfd_pkg::t_result got);
            htfd_pkg::t_result want;
            if (expected_readings.size() == 0) begin
                report($sformatf("result beat with nothing pending: status %0d", got.status));
                return;
            end
            want = expected_readings.pop_front();
            if (got.status !== want.status) begin
                report($sformatf("status %0d, predicted %0d", got.status, want.status));
            end
            if (got.temperature_tenths !== want.temperature_tenths) begin
                report($sformatf("temperature %0d, predicted %0d",
                                 got.temperature_tenths, want.temperature_tenths));
            end
            if (got.humidity_tenths !== want.humidity_tenths) begin
                report($sformatf("humidity %0d, predicted %0d",
                                 got.humidity_tenths, want.humidity_tenths));
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    reading_scoreboard sb = new();
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int beats_sent    = 0;
    bit pressure_go   = 1'b0;

    humidity_temp_frame_decoder DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic set_phase(input idle_phase_e ph);
        case (ph)
            PH_STEADY: begin
                src_idle_pct = 0;  sink_stall_pct = 0;
            end
            PH_SRC_GAPS: begin
                src_idle_pct = 45; sink_stall_pct = 0;
            end
            PH_SINK_STALLS: begin
                src_idle_pct = 0;  sink_stall_pct = 45;
            end
            default: begin
                src_idle_pct = 31; sink_stall_pct = 31;
            end
        endcase
    endtask

    task automatic send_beat(input logic [7:0] data, input bit start, input bit nack);
        htfd_pkg::t_item it;
        it.rx_byte     = data;
        it.frame_start = start;
        it.bus_nack    = nack;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= {nack, start};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_input(it);
        beats_sent++;
    endtask

    // Sends the first cut_at bytes of a frame built from six payload bytes and their CRC.
    task automatic send_frame(input logic [7:0] body [6], input bit mark_start,
                              input bit corrupt, input int cut_at, input bit nack_at_cut);
        logic [7:0]  fb [8];
        logic [15:0] crc;
        int          idx;
        crc = htfd_pkg::CRC_INIT;
        for (int i = 0; i < 6; i++) begin
            fb[i] = body[i];
            crc   = reading_scoreboard::crc16_step(crc, body[i]);
        end
        fb[6] = crc[7:0];
        fb[7] = crc[15:8];
        if (corrupt) begin
            idx = $urandom_range(7);
            fb[idx] = fb[idx] ^ (8'd1 << $urandom_range(7));
        end
        for (int i = 0; i < cut_at; i++) begin
            send_beat(fb[i], mark_start && (i == 0), 1'b0);
        end
        if (cut_at < htfd_pkg::FRAME_BYTES && nack_at_cut) begin
            send_beat(8'($urandom), 1'($urandom), 1'b1);
        end
    endtask

    function automatic logic [7:0] field_byte();
        case ($urandom_range(5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        logic [7:0] body [6];
        int         pick;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_phase(PH_STEADY);
        // A nack ignores its byte and its start flag.
        send_beat(8'hA5, 1'b1, 1'b1);
        body = '{8'h03, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_frame(body, 1'b1, 1'b0, htfd_pkg::FRAME_BYTES, 1'b0);
        // Negative zero, and a frame that follows the previous one without a start flag.
        body = '{8'h03, 8'h04, 8'h00, 8'h00, 8'h80, 8'h00};
        send_frame(body, 1'b0, 1'b0, htfd_pkg::FRAME_BYTES, 1'b0);
        // Truncated frame; the start flag of the next one must restart the decoding.
        body = '{8'h03, 8'h04, 8'h01, 8'hF4, 8'h00, 8'hFA};
        send_frame(body, 1'b1, 1'b0, 2, 1'b0);
        body = '{8'h00, 8'hFF, 8'h02, 8'h58, 8'h7F, 8'hFF};
        send_frame(body, 1'b1, 1'b1, htfd_pkg::FRAME_BYTES, 1'b0);

        // The sink holds off for a long stretch at the start of the steady phase.
        pressure_go = 1'b1;
        while (beats_sent < ITEM_TARGET) begin
            set_phase(idle_phase_e'((beats_sent / PHASE_BEATS) % 4));
            body[0] = $urandom_range(1) ? 8'h03 : 8'($urandom);
            body[1] = $urandom_range(1) ? 8'h04 : 8'($urandom);
            for (int i = 2; i < 6; i++) begin
                body[i] = field_byte();
            end
            if ($urandom_range(15) == 0) begin
                body[4] = 8'h80;
                body[5] = 8'h00;
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_frame(body, $urandom_range(99) < 85, $urandom_range(99) < 15,
                           htfd_pkg::FRAME_BYTES, 1'b0);
            end else if (pick < 80) begin
                send_frame(body, 1'b1, 1'b0, $urandom_range(7), 1'b1);
            end else if (pick < 90) begin
                send_frame(body, $urandom_range(1), 1'b0, $urandom_range(1, 7), 1'b0);
            end else begin
                repeat ($urandom_range(1, 5)) begin
                    send_beat(8'($urandom), 1'($urandom), $urandom_range(3) == 0);
                end
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : result_sink
        htfd_pkg::t_result got;
        int                hold_left;
        bit                hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) begin
                got.status             = m_tuser;
                got.temperature_tenths = m_tdata[15:0];
                got.humidity_tenths    = m_tdata[31:16];
                sb.check_result(got);
            end
            if (pressure_go && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule
